>>> sv/btxq_pkg.sv
// Package for the binary trie XOR query block.
// Holds the request mode codes, status codes and fixed port widths.
// No dependencies.
package btxq_pkg;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 20;
  localparam int ANS_W    = 20;
  localparam int STATUS_W = 2;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INSERT  = 3'd0;
  localparam mode_t MODE_DELETE  = 3'd1;
  localparam mode_t MODE_MAX_XOR = 3'd2;
  localparam mode_t MODE_XOR_MEX = 3'd3;
  localparam mode_t MODE_CLEAR   = 3'd4;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;

endpackage

>>> sv/binary_trie_xor_query.sv
// Binary trie over KEY_BITS-bit keys: insert, delete, max-XOR and XOR-mex queries, clear.
// Node store is one synchronous single-read, single-write memory inside this module.
// Depends on btxq_pkg.
//
// Usage:
//   A request (in_mode, in_key) is taken at a rising edge where start is high and busy
//   is low. Exactly one result (out_answer, out_status) follows, shown for one cycle
//   with out_valid high; the receiver cannot stall it and must take it then.
//   One request is in flight at a time; busy stays high until the result is shown.
// Steps, each trie level needing a registered memory read:
//   clear, unused modes, and deletes and queries on an empty trie: answered from idle.
//   insert: path search walk, capacity check, update walk.
//   delete: presence walk, decrement walk.
//   queries: node read plus child-count read per level.
//   The result strobe is registered from the last step; busy drops with it.
// Reset: the trie is empty (root 0) and the allocator restarts at node 1. The node
//   memory is not cleared; every node is initialized when it is allocated.
module binary_trie_xor_query
  import btxq_pkg::*;
#(
  parameter int KEY_BITS      = 20,
  parameter int NODE_CAPACITY = 65536,
  parameter int COUNT_BITS    = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_key,
  output logic                out_valid,
  output logic [ANS_W-1:0]    out_answer,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IW    = $clog2(NODE_CAPACITY);
  localparam int FW    = $clog2(NODE_CAPACITY + 1);
  localparam int RW    = $clog2(KEY_BITS + 1);
  localparam int MW    = $clog2(KEY_BITS + 2);
  localparam int SW    = FW + MW;
  localparam int CMP_W = ((COUNT_BITS > KEY_BITS) ? COUNT_BITS : KEY_BITS) + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [KEY_BITS-1:0]   TOP_BIT   = {1'b1, {(KEY_BITS-1){1'b0}}};

  typedef struct packed {
    logic [IW-1:0]         link1;
    logic [IW-1:0]         link0;
    logic [COUNT_BITS-1:0] count;
  } node_t;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IWALK  = 4'd1;
  localparam logic [3:0] S_ICHECK = 4'd2;
  localparam logic [3:0] S_IMOD   = 4'd3;
  localparam logic [3:0] S_DWALK  = 4'd4;
  localparam logic [3:0] S_DMOD   = 4'd5;
  localparam logic [3:0] S_QCUR   = 4'd6;
  localparam logic [3:0] S_QCAND  = 4'd7;

  node_t mem [NODE_CAPACITY];
  node_t rd_data_r;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  node_t         wr_data;

  logic [3:0]          state_r, state_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] key_org_r, key_org_nxt;
  logic [KEY_BITS-1:0] size_r, size_nxt;
  logic [KEY_BITS-1:0] res_r, res_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [IW-1:0]       cur_idx_r, cur_idx_nxt;
  logic [IW-1:0]       alt_r, alt_nxt;
  logic                fresh_r, fresh_nxt;
  logic [MW-1:0]       missing_r, missing_nxt;
  logic                qmax_r, qmax_nxt;
  logic [FW-1:0]       free_r, free_nxt;
  logic [IW-1:0]       root_r, root_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ANS_W-1:0]    out_answer_r, out_answer_nxt;
  status_t             out_status_r, out_status_nxt;

  node_t               n;
  logic                bit_k;
  logic [IW-1:0]       nxt_idx, cand, alt;
  logic                take, set_bit;
  logic [KEY_BITS-1:0] res2;
  logic [KEY_BITS-1:0] key_in;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign key_in = KEY_BITS'(in_key);
  assign bit_k  = key_r[KEY_BITS-1];

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    key_org_nxt    = key_org_r;
    size_nxt       = size_r;
    res_nxt        = res_r;
    rem_nxt        = rem_r;
    cur_idx_nxt    = cur_idx_r;
    alt_nxt        = alt_r;
    fresh_nxt      = fresh_r;
    missing_nxt    = missing_r;
    qmax_nxt       = qmax_r;
    free_nxt       = free_r;
    root_nxt       = root_r;
    out_valid_nxt  = 1'b0;
    out_answer_nxt = out_answer_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    rd_addr        = root_r;
    wr_en          = 1'b0;
    wr_addr        = cur_idx_r;
    wr_data        = rd_data_r;
    n              = rd_data_r;
    nxt_idx        = bit_k ? rd_data_r.link1 : rd_data_r.link0;
    cand           = '0;
    alt            = '0;
    take           = 1'b0;
    set_bit        = 1'b0;
    res2           = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt        = key_in;
          key_org_nxt    = key_in;
          size_nxt       = TOP_BIT;
          res_nxt        = '0;
          rem_nxt        = RW'(KEY_BITS);
          qmax_nxt       = (in_mode == MODE_MAX_XOR);
          out_answer_nxt = '0;
          out_status_nxt = ST_OK;
          unique case (in_mode) inside
            MODE_INSERT: begin
              if (root_r == '0) begin
                missing_nxt = MW'(KEY_BITS + 1);
                state_nxt   = S_ICHECK;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_IWALK;
              end
            end
            MODE_DELETE: begin
              if (root_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ABSENT;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DWALK;
              end
            end
            MODE_MAX_XOR, MODE_XOR_MEX: begin
              if (root_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_QCUR;
              end
            end
            MODE_CLEAR: begin
              root_nxt      = '0;
              free_nxt      = FW'(1);
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_IWALK: begin
        if (rem_r == RW'(KEY_BITS) && rd_data_r.count == COUNT_MAX) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end else if (rem_r == '0) begin
          missing_nxt = '0;
          state_nxt   = S_ICHECK;
        end else if (nxt_idx == '0) begin
          missing_nxt = MW'(rem_r);
          state_nxt   = S_ICHECK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nxt_idx;
          key_nxt = key_r << 1;
          rem_nxt = rem_r - RW'(1);
        end
      end

      S_ICHECK: begin
        if (SW'(free_r) + SW'(missing_r) > SW'(NODE_CAPACITY)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          key_nxt   = key_org_r;
          rem_nxt   = RW'(KEY_BITS);
          state_nxt = S_IMOD;
          if (root_r == '0) begin
            root_nxt    = free_r[IW-1:0];
            cur_idx_nxt = free_r[IW-1:0];
            free_nxt    = free_r + FW'(1);
            fresh_nxt   = 1'b1;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = root_r;
            cur_idx_nxt = root_r;
            fresh_nxt   = 1'b0;
          end
        end
      end

      S_IMOD: begin
        n       = fresh_r ? node_t'('0) : rd_data_r;
        n.count = n.count + COUNT_BITS'(1);
        nxt_idx = bit_k ? n.link1 : n.link0;
        wr_en   = 1'b1;
        if (rem_r == '0) begin
          wr_data       = n;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (nxt_idx == '0) begin
            nxt_idx   = free_r[IW-1:0];
            free_nxt  = free_r + FW'(1);
            fresh_nxt = 1'b1;
            if (bit_k) begin
              n.link1 = nxt_idx;
            end else begin
              n.link0 = nxt_idx;
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = nxt_idx;
            fresh_nxt = 1'b0;
          end
          wr_data     = n;
          cur_idx_nxt = nxt_idx;
          key_nxt     = key_r << 1;
          rem_nxt     = rem_r - RW'(1);
        end
      end

      S_DWALK: begin
        if (rem_r == '0) begin
          if (rd_data_r.count == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_ABSENT;
            state_nxt      = S_IDLE;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = root_r;
            cur_idx_nxt = root_r;
            key_nxt     = key_org_r;
            rem_nxt     = RW'(KEY_BITS);
            state_nxt   = S_DMOD;
          end
        end else if (nxt_idx == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ABSENT;
          state_nxt      = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nxt_idx;
          key_nxt = key_r << 1;
          rem_nxt = rem_r - RW'(1);
        end
      end

      S_DMOD: begin
        n       = rd_data_r;
        n.count = n.count - COUNT_BITS'(1);
        wr_en   = 1'b1;
        wr_data = n;
        if (rem_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = nxt_idx;
          cur_idx_nxt = nxt_idx;
          key_nxt     = key_r << 1;
          rem_nxt     = rem_r - RW'(1);
        end
      end

      S_QCUR: begin
        cand = (qmax_r ^ bit_k) ? rd_data_r.link1 : rd_data_r.link0;
        alt  = (qmax_r ^ bit_k) ? rd_data_r.link0 : rd_data_r.link1;
        if (cand != '0) begin
          rd_en     = 1'b1;
          rd_addr   = cand;
          alt_nxt   = alt;
          state_nxt = S_QCAND;
        end else if (!qmax_r || alt == '0 || rem_r == RW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ANS_W'(res_r);
          state_nxt      = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = alt;
          key_nxt  = key_r << 1;
          size_nxt = size_r >> 1;
          rem_nxt  = rem_r - RW'(1);
        end
      end

      S_QCAND: begin
        take    = qmax_r ? (rd_data_r.count != '0)
                         : (CMP_W'(rd_data_r.count) < CMP_W'(size_r));
        set_bit = qmax_r ? take : !take;
        res2    = set_bit ? (res_r | size_r) : res_r;
        res_nxt = res2;
        if ((!take && alt_r == '0) || rem_r == RW'(1)) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ANS_W'(res2);
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = !take;
          rd_addr   = alt_r;
          key_nxt   = key_r << 1;
          size_nxt  = size_r >> 1;
          rem_nxt   = rem_r - RW'(1);
          state_nxt = S_QCUR;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      free_r      <= FW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    key_org_r    <= key_org_nxt;
    size_r       <= size_nxt;
    res_r        <= res_nxt;
    rem_r        <= rem_nxt;
    cur_idx_r    <= cur_idx_nxt;
    alt_r        <= alt_nxt;
    fresh_r      <= fresh_nxt;
    missing_r    <= missing_nxt;
    qmax_r       <= qmax_nxt;
    out_answer_r <= out_answer_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

endmodule

>>> tb/trie_xor_checker.sv
// Checker for binary_trie_xor_query: watches the request and result channels,
// keeps its own trie of the stored keys and compares every result in order.
// Depends on btxq_pkg.
module trie_xor_checker
  import btxq_pkg::*;
#(
  parameter int KEY_BITS      = 20,
  parameter int NODE_CAPACITY = 65536,
  parameter int COUNT_BITS    = 21
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_key,
  input  logic                out_valid,
  input  logic [ANS_W-1:0]    out_answer,
  input  logic [STATUS_W-1:0] out_status,
  output int                  errors,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W     = $clog2(NODE_CAPACITY);
  localparam int MAX_NOTES = 40;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [IDX_W-1:0]      link0;
    logic [IDX_W-1:0]      link1;
    logic [COUNT_BITS-1:0] cnt;
  } node_t;

  typedef struct {
    mode_t            mode;
    key_t             key;
    logic [ANS_W-1:0] answer;
    status_t          status;
  } trie_reply_t;

  node_t       nodes [NODE_CAPACITY];
  int unsigned next_free = 1;
  int unsigned root = 0;
  trie_reply_t replies_due [$];
  int          mismatches = 0;

  function automatic int unsigned child(int unsigned idx, logic b);
    return b ? 32'(nodes[idx].link1) : 32'(nodes[idx].link0);
  endfunction

  function automatic int unsigned count_of(int unsigned idx);
    return (idx == 0) ? 0 : 32'(nodes[idx].cnt);
  endfunction

  function automatic int unsigned alloc_node();
    int unsigned idx;
    idx = next_free;
    next_free++;
    nodes[idx] = '0;
    return idx;
  endfunction

  function automatic status_t trie_insert(key_t k);
    int unsigned missing;
    int unsigned cur;
    int unsigned nxt;
    logic        b;
    missing = KEY_BITS + 1;
    if (root != 0) begin
      if (nodes[root].cnt == '1) return ST_FULL;
      missing = 0;
      cur = root;
      for (int d = 0; d < KEY_BITS; d++) begin
        nxt = child(cur, k[KEY_BITS-1-d]);
        if (nxt == 0) begin
          missing = KEY_BITS - d;
          break;
        end
        cur = nxt;
      end
    end
    if (next_free + missing > NODE_CAPACITY) return ST_FULL;
    if (root == 0) root = alloc_node();
    cur = root;
    nodes[cur].cnt = nodes[cur].cnt + 1'b1;
    for (int d = 0; d < KEY_BITS; d++) begin
      b = k[KEY_BITS-1-d];
      nxt = child(cur, b);
      if (nxt == 0) begin
        nxt = alloc_node();
        if (b) nodes[cur].link1 = IDX_W'(nxt);
        else nodes[cur].link0 = IDX_W'(nxt);
      end
      cur = nxt;
      nodes[cur].cnt = nodes[cur].cnt + 1'b1;
    end
    return ST_OK;
  endfunction

  function automatic status_t trie_delete(key_t k);
    int unsigned cur;
    cur = root;
    if (cur == 0) return ST_ABSENT;
    for (int d = 0; d < KEY_BITS; d++) begin
      cur = child(cur, k[KEY_BITS-1-d]);
      if (cur == 0) return ST_ABSENT;
    end
    if (nodes[cur].cnt == '0) return ST_ABSENT;
    cur = root;
    nodes[cur].cnt = nodes[cur].cnt - 1'b1;
    for (int d = 0; d < KEY_BITS; d++) begin
      cur = child(cur, k[KEY_BITS-1-d]);
      nodes[cur].cnt = nodes[cur].cnt - 1'b1;
    end
    return ST_OK;
  endfunction

  function automatic logic [ANS_W-1:0] trie_max_xor(key_t k);
    logic [ANS_W-1:0] res;
    int unsigned      cur;
    int unsigned      other;
    logic             b;
    res = '0;
    cur = root;
    for (int d = 0; d < KEY_BITS && cur != 0; d++) begin
      b = k[KEY_BITS-1-d];
      other = child(cur, ~b);
      if (count_of(other) != 0) begin
        res[KEY_BITS-1-d] = 1'b1;
        cur = other;
      end else begin
        cur = child(cur, b);
      end
    end
    return res;
  endfunction

  function automatic logic [ANS_W-1:0] trie_xor_mex(key_t k);
    logic [ANS_W-1:0] res;
    logic [ANS_W-1:0] size;
    int unsigned      cur;
    int unsigned      same;
    logic             b;
    res = '0;
    cur = root;
    for (int d = 0; d < KEY_BITS && cur != 0; d++) begin
      b = k[KEY_BITS-1-d];
      size = '0;
      size[KEY_BITS-1-d] = 1'b1;
      same = child(cur, b);
      if (count_of(same) < 32'(size)) begin
        cur = same;
      end else begin
        res = res | size;
        cur = child(cur, ~b);
      end
    end
    return res;
  endfunction

  function automatic trie_reply_t trie_apply(mode_t m, key_t k);
    trie_reply_t r;
    r.mode = m;
    r.key = k;
    r.answer = '0;
    r.status = ST_OK;
    case (m)
      MODE_INSERT:  r.status = trie_insert(k);
      MODE_DELETE:  r.status = trie_delete(k);
      MODE_MAX_XOR: r.answer = trie_max_xor(k);
      MODE_XOR_MEX: r.answer = trie_xor_mex(k);
      MODE_CLEAR: begin
        next_free = 1;
        root = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_field(string what, int unsigned want, int unsigned got, trie_reply_t r);
    if (mismatches < MAX_NOTES)
      $display("%0t: %s mismatch, mode %0d key %h: expected %h, actual %h",
               $time, what, r.mode, r.key, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    trie_reply_t want;
    if (!rst_n) begin
      next_free = 1;
      root = 0;
      replies_due.delete();
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          if (mismatches < MAX_NOTES)
            $display("%0t: result with nothing due: expected none, actual answer %h status %0d",
                     $time, out_answer, out_status);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (out_answer !== want.answer) flag_field("answer", want.answer, out_answer, want);
          if (out_status !== want.status) flag_field("status", want.status, out_status, want);
        end
      end
      if (start && !busy) replies_due.push_back(trie_apply(in_mode, in_key));
    end
    outstanding <= replies_due.size();
    errors <= mismatches;
  end

endmodule

>>> tb/tb.sv
// Top of the binary_trie_xor_query testbench: clock, reset and request stimulus
// (directed corners, a spread of bit-reversed keys, random mixed traffic) and the verdict.
// Depends on btxq_pkg, binary_trie_xor_query and trie_xor_checker.
module tb
  import btxq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD     = 8;
  localparam int RAND_ITEMS = 1200;
  localparam int FILL_ITEMS = 200;
  localparam int TAIL_ITEMS = 40;
  localparam int SETTLE     = 64;
  localparam int LIMIT      = 6_000_000;

  localparam mode_t MODE_SPARE_A = 3'd5;
  localparam mode_t MODE_SPARE_B = 3'd6;
  localparam mode_t MODE_SPARE_C = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [MODE_W-1:0]   in_mode = '0;
  logic [KEY_W-1:0]    in_key = '0;
  logic                busy;
  logic                out_valid;
  logic [ANS_W-1:0]    out_answer;
  logic [STATUS_W-1:0] out_status;

  int               errors;
  int               outstanding;
  int               sent = 0;
  int               cycles = 0;
  bit               calm = 1'b0;
  logic [15:0]      cluster_hi [2];
  logic [KEY_W-1:0] live_keys [$];

  always #(PERIOD/2) clk = ~clk;

  binary_trie_xor_query dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_mode    (in_mode),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_answer (out_answer),
    .out_status (out_status)
  );

  trie_xor_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_answer  (out_answer),
    .out_status  (out_status),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 80) return $urandom_range(1, 10);
    if (r < 95) return $urandom_range(11, 50);
    return $urandom_range(51, 150);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return {cluster_hi[$urandom_range(0, 1)], 4'($urandom_range(0, 15))};
    if (r < 75 && live_keys.size() > 0) return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] mirror_key(int n);
    logic [KEY_W-1:0] k;
    for (int b = 0; b < KEY_W; b++) k[b] = n[KEY_W-1-b];
    return k;
  endfunction

  task automatic send(mode_t m, logic [KEY_W-1:0] k);
    int gap;
    start <= 1'b1;
    in_mode <= m;
    in_key <= k;
    do @(posedge clk); while (busy);
    sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int               r;
    int               j;
    logic [KEY_W-1:0] k;
    cluster_hi[0] = 16'($urandom);
    cluster_hi[1] = cluster_hi[0] ^ 16'h0001;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty trie, duplicates, absent deletes, spare modes, clear
    send(MODE_MAX_XOR, 20'h00000);
    send(MODE_XOR_MEX, 20'hFFFFF);
    send(MODE_DELETE, 20'h00000);
    send(MODE_INSERT, 20'h00000);
    send(MODE_INSERT, 20'hFFFFF);
    send(MODE_MAX_XOR, 20'h00000);
    send(MODE_MAX_XOR, 20'hFFFFF);
    send(MODE_XOR_MEX, 20'h00000);
    send(MODE_INSERT, 20'h00000);
    send(MODE_XOR_MEX, 20'hFFFFF);
    send(MODE_DELETE, 20'h00000);
    send(MODE_DELETE, 20'h00000);
    send(MODE_DELETE, 20'h00000);
    send(MODE_DELETE, 20'h12345);
    send(MODE_INSERT, 20'h00000);
    send(MODE_INSERT, 20'h00001);
    send(MODE_INSERT, 20'h00002);
    send(MODE_INSERT, 20'h00003);
    send(MODE_XOR_MEX, 20'h00000);
    send(MODE_SPARE_A, 20'hFFFFF);
    send(MODE_SPARE_B, 20'h55555);
    send(MODE_SPARE_C, 20'hAAAAA);
    send(MODE_CLEAR, 20'hFFFFF);
    send(MODE_MAX_XOR, 20'h55555);
    send(MODE_INSERT, 20'hAAAAA);
    send(MODE_MAX_XOR, 20'h55555);

    // spread bit-reversed keys across the upper trie levels
    calm = 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++) send(MODE_INSERT, mirror_key(i));
    calm = 1'b0;
    repeat (TAIL_ITEMS) begin
      r = $urandom_range(0, 4);
      j = $urandom_range(0, FILL_ITEMS - 1);
      case (r)
        0: send(MODE_INSERT, mirror_key(j));
        1: send(MODE_INSERT, KEY_W'($urandom));
        2: send(MODE_DELETE, mirror_key(j));
        3: send(MODE_MAX_XOR, KEY_W'($urandom));
        default: send(MODE_XOR_MEX, KEY_W'($urandom));
      endcase
    end
    send(MODE_CLEAR, KEY_W'($urandom));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = ((i / 100) % 4) == 2;
      if (i == RAND_ITEMS / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 36) begin
        k = pick_key();
        live_keys.push_back(k);
        if (live_keys.size() > 256) live_keys.delete(0);
        send(MODE_INSERT, k);
      end else if (r < 58) begin
        if (live_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
          j = $urandom_range(0, live_keys.size() - 1);
          k = live_keys[j];
          live_keys.delete(j);
        end else begin
          k = pick_key();
        end
        send(MODE_DELETE, k);
      end else if (r < 74) begin
        send(MODE_MAX_XOR, pick_key());
      end else if (r < 90) begin
        send(MODE_XOR_MEX, pick_key());
      end else if (r < 92) begin
        live_keys.delete();
        send(MODE_CLEAR, pick_key());
      end else if (r < 96) begin
        send(MODE_W'(MODE_SPARE_A + 3'($urandom_range(0, 2))), pick_key());
      end else begin
        send(MODE_INSERT, KEY_W'($urandom));
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d requests: directed corners, %0d inserts of bit-reversed keys,",
             sent, FILL_ITEMS);
    $display("and %0d random inserts, deletes, queries and clears with idle gaps.", RAND_ITEMS);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/btxq_pkg.sv
sv/binary_trie_xor_query.sv
tb/trie_xor_checker.sv
tb/tb.sv
